>>> hw/rtl/pfr_pkg.sv
// shared constants and types of the page frame replacement block
`default_nettype none

package pfr_pkg;

  localparam int unsigned FramesDef    = 64;
  localparam int unsigned StampBitsDef = 32;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned FCNT_W = 7;

  localparam logic [FCNT_W-1:0] FCNT_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_RELEASE = 2'd3
  } pfr_mode_e;

  typedef enum logic {
    REG_POLICY      = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } pfr_reg_e;

endpackage

`default_nettype wire

>>> hw/rtl/pfr_ram.sv
// generic single write port ram with registered, write-first read
`default_nettype none

module pfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // same-address read sees the data being written
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/page_frame_replacement.sv
// page frame replacement: frame table in ram, sequenced lru and enhanced clock search
//
// channel   direction  signals                                        handshake
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i                write when cfg_we_i
// request   in         start, mode_i, frame_index_i                   start && !busy
// result    out        done_o, frame_out_o, evicted_o,                one-cycle strobe
//                      write_back_o, status_o
//
// access or release: read the frame, then update it and report; an out-of-range index
// reports straight from idle. allocate: scan from frame 0 for the lowest free frame, else
// take an lru victim after the scan; the clock search follows the scan, one frame a cycle
// through the single ram read port.
// after reset a clearing pass sweeps the frame table; busy is high.
// results cannot be stalled: each item is shown for one cycle as the block goes idle.
`default_nettype none

module page_frame_replacement
  import pfr_pkg::*;
#(
  parameter int unsigned FRAMES     = FramesDef,
  parameter int unsigned STAMP_BITS = StampBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [FCNT_W-1:0] cfg_data_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [IDX_W-1:0]  frame_index_i,
  output logic                   done_o,
  output logic      [IDX_W-1:0]  frame_out_o,
  output logic                   evicted_o,
  output logic                   write_back_o,
  output logic                   status_o
);

  localparam int unsigned FW = $clog2(FRAMES);
  localparam int unsigned CW = ($clog2(FRAMES + 1) > FCNT_W) ? $clog2(FRAMES + 1) : FCNT_W;
  localparam int unsigned WW = STAMP_BITS + 3;
  localparam int unsigned OCC_B = STAMP_BITS + 2;
  localparam int unsigned USE_B = STAMP_BITS + 1;
  localparam int unsigned MOD_B = STAMP_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CLK   = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

  logic [2:0]            state_q, state_d;
  logic                  policy_q;
  logic [FCNT_W-1:0]     fcount_q;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  logic [FW-1:0]         hand_q, hand_d;
  logic [FW-1:0]         chk_q, chk_d;
  logic [CW-1:0]         k_q, k_d;
  logic                  pass_q, pass_d;
  logic [FW-1:0]         best_q, best_d;
  logic [STAMP_BITS-1:0] best_age_q, best_age_d;
  logic                  best_mod_q, best_mod_d;
  logic [FW-1:0]         vic_q, vic_d;
  logic                  vic_ev_q, vic_ev_d;
  logic                  vic_wb_q, vic_wb_d;
  pfr_mode_e             mode_q, mode_d;
  logic                  done_q, done_d;
  logic [IDX_W-1:0]      fo_q, fo_d;
  logic                  ev_q, ev_d;
  logic                  wb_q, wb_d;
  logic                  st_q, st_d;

  logic [FW-1:0]         ram_raddr;
  logic [FW-1:0]         ram_waddr;
  logic                  ram_we;
  logic [WW-1:0]         ram_wdata;
  logic [WW-1:0]         ram_rdata;

  logic [CW-1:0]         fc_ext;
  logic [CW-1:0]         n_act;
  logic [CW-1:0]         last_addr;
  logic                  chk_last;
  logic [FW-1:0]         chk_next;
  logic [FW-1:0]         hand_start;
  logic                  idx_in_range;
  logic [FW-1:0]         idx_frame;
  logic                  rd_occ, rd_use, rd_mod;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic [STAMP_BITS-1:0] age;
  logic                  lru_take;

  pfr_ram #(
    .WIDTH (WW),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_occ   = ram_rdata[OCC_B];
  assign rd_use   = ram_rdata[USE_B];
  assign rd_mod   = ram_rdata[MOD_B];
  assign rd_stamp = ram_rdata[STAMP_BITS-1:0];

  // active frame count clamped to 1..FRAMES
  assign fc_ext = CW'(fcount_q);
  always_comb begin
    if (fc_ext == '0) begin
      n_act = CW'(1);
    end else if (fc_ext > CW'(FRAMES)) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = fc_ext;
    end
  end

  assign last_addr    = n_act - CW'(1);
  assign chk_last     = (CW'(chk_q) == last_addr);
  assign chk_next     = chk_last ? '0 : chk_q + FW'(1);
  assign hand_start   = (CW'(hand_q) < n_act) ? hand_q : '0;
  assign idx_in_range = (CW'(frame_index_i) < n_act);
  assign idx_frame    = FW'(frame_index_i);
  assign age          = stamp_q - rd_stamp;
  assign lru_take     = (chk_q == '0) || (age > best_age_q);

  always_comb begin
    state_d    = state_q;
    stamp_d    = stamp_q;
    hand_d     = hand_q;
    chk_d      = chk_q;
    k_d        = k_q;
    pass_d     = pass_q;
    best_d     = best_q;
    best_age_d = best_age_q;
    best_mod_d = best_mod_q;
    vic_d      = vic_q;
    vic_ev_d   = vic_ev_q;
    vic_wb_d   = vic_wb_q;
    mode_d     = mode_q;
    done_d     = 1'b0;
    fo_d       = fo_q;
    ev_d       = ev_q;
    wb_d       = wb_q;
    st_d       = st_q;
    ram_raddr  = chk_next;
    ram_we     = 1'b0;
    ram_waddr  = chk_q;
    ram_wdata  = ram_rdata;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        chk_d     = chk_q + FW'(1);
        if (CW'(chk_q) == CW'(FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = (mode_i == MODE_ALLOC) ? '0 : idx_frame;
        if (start) begin
          mode_d = pfr_mode_e'(mode_i);
          if (mode_i == MODE_ALLOC) begin
            chk_d   = '0;
            state_d = S_SCAN;
          end else if (!idx_in_range) begin
            done_d = 1'b1;
            fo_d   = frame_index_i;
            ev_d   = 1'b0;
            wb_d   = 1'b0;
            st_d   = 1'b1;
          end else begin
            chk_d   = idx_frame;
            state_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        if (mode_q == MODE_RELEASE) begin
          ram_we    = 1'b1;
          ram_wdata = {3'b000, rd_stamp};
        end else if (rd_occ) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, 1'b1, rd_mod | (mode_q == MODE_WRITE), stamp_q};
          stamp_d   = stamp_q + STAMP_BITS'(1);
        end
        done_d  = 1'b1;
        fo_d    = IDX_W'(chk_q);
        ev_d    = 1'b0;
        wb_d    = 1'b0;
        st_d    = 1'b0;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        // lowest free frame, with the oldest stamp tracked on the way
        chk_d = chk_next;
        if (!rd_occ) begin
          vic_d    = chk_q;
          vic_ev_d = 1'b0;
          vic_wb_d = 1'b0;
          state_d  = S_WR;
        end else begin
          if (lru_take) begin
            best_d     = chk_q;
            best_age_d = age;
            best_mod_d = rd_mod;
          end
          if (chk_last) begin
            if (!policy_q) begin
              vic_d    = lru_take ? chk_q : best_q;
              vic_wb_d = lru_take ? rd_mod : best_mod_q;
              vic_ev_d = 1'b1;
              state_d  = S_WR;
            end else begin
              ram_raddr = hand_start;
              chk_d     = hand_start;
              k_d       = '0;
              pass_d    = 1'b0;
              state_d   = S_CLK;
            end
          end
        end
      end
      S_CLK: begin
        // first pass seeks clean unused frames, second seeks dirty ones and clears use
        chk_d = chk_next;
        k_d   = k_q + CW'(1);
        if (!rd_use && (rd_mod == pass_q)) begin
          vic_d    = chk_q;
          vic_ev_d = 1'b1;
          vic_wb_d = pass_q;
          state_d  = S_WR;
        end else begin
          if (pass_q) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_occ, 1'b0, rd_mod, rd_stamp};
          end
          if (k_q == last_addr) begin
            k_d    = '0;
            pass_d = ~pass_q;
          end
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = vic_q;
        ram_wdata = {1'b1, 1'b1, 1'b0, stamp_q};
        stamp_d   = stamp_q + STAMP_BITS'(1);
        if (policy_q && vic_ev_q) begin
          hand_d = vic_q;
        end
        done_d  = 1'b1;
        fo_d    = IDX_W'(vic_q);
        ev_d    = vic_ev_q;
        wb_d    = vic_wb_q;
        st_d    = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      policy_q <= 1'b0;
      fcount_q <= FCNT_RESET;
      stamp_q  <= '0;
      hand_q   <= '0;
      chk_q    <= '0;
      k_q      <= '0;
      pass_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      stamp_q <= stamp_d;
      hand_q  <= hand_d;
      chk_q   <= chk_d;
      k_q     <= k_d;
      pass_q  <= pass_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (pfr_reg_e'(cfg_idx_i))
          REG_POLICY:      policy_q <= cfg_data_i[0];
          REG_FRAME_COUNT: fcount_q <= cfg_data_i;
          default:         policy_q <= policy_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_age_q <= best_age_d;
    best_mod_q <= best_mod_d;
    vic_q      <= vic_d;
    vic_ev_q   <= vic_ev_d;
    vic_wb_q   <= vic_wb_d;
    mode_q     <= mode_d;
    fo_q       <= fo_d;
    ev_q       <= ev_d;
    wb_q       <= wb_d;
    st_q       <= st_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign frame_out_o  = fo_q;
  assign evicted_o    = ev_q;
  assign write_back_o = wb_q;
  assign status_o     = st_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while block still busy");

  a_range_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i != MODE_ALLOC) && !idx_in_range) |=> (done_o && status_o))
    else $error("out of range item did not report status");

  a_wb_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_back_o) |-> evicted_o)
    else $error("write-back without eviction");

  a_stamp_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |=> (stamp_q == STAMP_BITS'($past(stamp_q) + 1'b1)))
    else $error("stamp counter did not advance on allocation");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !done_o)
    else $error("result during clearing pass");

endmodule

`default_nettype wire

>>> tb/sv/tb_page_frame_replacement.sv
// self-checking testbench for the page frame replacement block: directed items, then random phases
`timescale 1ns / 1ps

class frame_table_sb;

  typedef struct packed {
    logic [5:0] frame;
    logic       evicted;
    logic       write_back;
    logic       status;
  } frame_result_t;

  bit            occupied[64];
  bit            referenced[64];
  bit            dirty[64];
  bit [31:0]     stamp[64];
  bit [31:0]     access_count;
  bit [5:0]      hand;
  bit            lru_off;
  bit [6:0]      frames_cfg;
  frame_result_t pending[$];
  int unsigned   errors;

  function new();
    frames_cfg = pfr_pkg::FCNT_RESET;
  endfunction

  function int unsigned active_frames();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > 64) return 64;
    return frames_cfg;
  endfunction

  function void set_reg(pfr_pkg::pfr_reg_e r, bit [6:0] value);
    if (r == pfr_pkg::REG_POLICY) lru_off = value[0];
    else frames_cfg = value;
  endfunction

  function void touch(int unsigned f);
    referenced[f] = 1'b1;
    stamp[f]      = access_count;
    access_count  = access_count + 1;
  endfunction

  // largest age wins, ties to the lowest frame
  function int unsigned pick_oldest(int unsigned n);
    int unsigned best;
    bit [31:0]   best_age;
    bit [31:0]   age;
    best     = 0;
    best_age = '0;
    for (int unsigned i = 0; i < n; i++) begin
      age = access_count - stamp[i];
      if (i == 0 || age > best_age) begin
        best_age = age;
        best     = i;
      end
    end
    return best;
  endfunction

  function int unsigned pick_clock(int unsigned n);
    int unsigned h;
    int unsigned i;
    h = (hand < n) ? hand : 0;
    for (int r = 0; r < 2; r++) begin
      for (int unsigned k = 0; k < n; k++) begin
        i = (h + k) % n;
        if (!referenced[i] && !dirty[i]) return i;
      end
      // second sweep takes a dirty frame, clearing use bits on the way
      for (int unsigned k = 0; k < n; k++) begin
        i = (h + k) % n;
        if (!referenced[i] && dirty[i]) return i;
        referenced[i] = 1'b0;
      end
    end
    return h;
  endfunction

  function void note_item(logic [1:0] mode_raw, logic [5:0] idx);
    pfr_pkg::pfr_mode_e m;
    frame_result_t      r;
    int unsigned        n;
    int unsigned        f;
    m            = pfr_pkg::pfr_mode_e'(mode_raw);
    n            = active_frames();
    r.frame      = idx;
    r.evicted    = 1'b0;
    r.write_back = 1'b0;
    r.status     = 1'b0;
    if (m == pfr_pkg::MODE_ALLOC) begin
      f = n;
      for (int unsigned i = 0; i < n; i++) begin
        if (!occupied[i]) begin
          f = i;
          break;
        end
      end
      if (f == n) begin
        f = lru_off ? pick_clock(n) : pick_oldest(n);
        if (lru_off) hand = f[5:0];
        r.evicted    = 1'b1;
        r.write_back = dirty[f];
      end
      occupied[f] = 1'b1;
      dirty[f]    = 1'b0;
      touch(f);
      r.frame = f[5:0];
    end else if (idx >= n) begin
      r.status = 1'b1;
    end else if (m == pfr_pkg::MODE_RELEASE) begin
      occupied[idx]   = 1'b0;
      referenced[idx] = 1'b0;
      dirty[idx]      = 1'b0;
    end else if (occupied[idx]) begin
      if (m == pfr_pkg::MODE_WRITE) dirty[idx] = 1'b1;
      touch(idx);
    end
    pending.push_back(r);
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [5:0] fo, logic ev, logic wb, logic st);
    frame_result_t exp;
    if (pending.size() == 0) begin
      report($sformatf("result with no item pending, frame %0d", fo));
      return;
    end
    exp = pending.pop_front();
    if (fo !== exp.frame)
      report($sformatf("frame_out %0d, wanted %0d", fo, exp.frame));
    if (ev !== exp.evicted)
      report($sformatf("evicted %b, wanted %b (frame %0d)", ev, exp.evicted, exp.frame));
    if (wb !== exp.write_back)
      report($sformatf("write_back %b, wanted %b (frame %0d)", wb, exp.write_back, exp.frame));
    if (st !== exp.status)
      report($sformatf("status %b, wanted %b (frame %0d)", st, exp.status, exp.frame));
  endtask

endclass

module tb_page_frame_replacement
  import pfr_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [FCNT_W-1:0] cfg_data_i;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] mode_i;
  logic [IDX_W-1:0]  frame_index_i;
  logic              done_o;
  logic [IDX_W-1:0]  frame_out_o;
  logic              evicted_o;
  logic              write_back_o;
  logic              status_o;

  frame_table_sb sb;
  int unsigned   cycles;

  page_frame_replacement dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .start,
    .busy,
    .mode_i,
    .frame_index_i,
    .done_o,
    .frame_out_o,
    .evicted_o,
    .write_back_o,
    .status_o
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // result checked before the new item is noted, so a stray result is never masked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) sb.check_result(frame_out_o, evicted_o, write_back_o, status_o);
      if (start && busy === 1'b0) sb.note_item(mode_i, frame_index_i);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[page_frame_replacement] ERROR");
      $finish;
    end
  end

  task send_item(pfr_mode_e m, logic [IDX_W-1:0] f);
    @(negedge clk_i);
    start         <= 1'b1;
    mode_i        <= m;
    frame_index_i <= f;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task hold_off(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task write_reg(pfr_reg_e r, logic [FCNT_W-1:0] value);
    @(negedge clk_i);
    start      <= 1'b0;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= value;
    sb.set_reg(r, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task wait_idle();
    hold_off(1);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task run_phase(logic [FCNT_W-1:0] policy_val, logic [FCNT_W-1:0] frames_val,
                 int unsigned count);
    int unsigned     n;
    int unsigned     burst;
    int unsigned     pick;
    pfr_mode_e       m;
    logic [IDX_W-1:0] f;
    write_reg(REG_POLICY, policy_val);
    write_reg(REG_FRAME_COUNT, frames_val);
    n     = sb.active_frames();
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
      end
      burst--;
      pick = $urandom_range(0, 99);
      if (pick < 40) m = MODE_ALLOC;
      else if (pick < 65) m = MODE_READ;
      else if (pick < 90) m = MODE_WRITE;
      else m = MODE_RELEASE;
      // mostly in range, now and then any index to hit the out-of-range status
      if ($urandom_range(0, 7) == 0) f = IDX_W'($urandom_range(0, 63));
      else f = IDX_W'($urandom_range(0, n - 1));
      send_item(m, f);
    end
    wait_idle();
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_POLICY;
    cfg_data_i    = '0;
    start         = 1'b0;
    mode_i        = MODE_ALLOC;
    frame_index_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset keeps busy high
    do @(posedge clk_i); while (busy !== 1'b0);

    // reset settings: lru over 64 frames, accesses to free frames first
    send_item(MODE_READ, 6'd63);
    send_item(MODE_WRITE, 6'd0);
    send_item(MODE_RELEASE, 6'd63);
    send_item(MODE_ALLOC, 6'd63);
    send_item(MODE_ALLOC, 6'd0);
    send_item(MODE_ALLOC, 6'd21);
    send_item(MODE_WRITE, 6'd1);
    send_item(MODE_READ, 6'd0);
    send_item(MODE_RELEASE, 6'd1);
    send_item(MODE_ALLOC, 6'd42);
    send_item(MODE_READ, 6'd63);
    wait_idle();

    // two frames under the clock policy: evictions at once, clean and dirty
    write_reg(REG_POLICY, 7'd1);
    write_reg(REG_FRAME_COUNT, 7'd2);
    send_item(MODE_ALLOC, 6'd0);
    send_item(MODE_WRITE, 6'd1);
    send_item(MODE_ALLOC, 6'd0);
    send_item(MODE_ALLOC, 6'd0);
    send_item(MODE_WRITE, 6'd0);
    send_item(MODE_WRITE, 6'd1);
    send_item(MODE_ALLOC, 6'd0);
    send_item(MODE_READ, 6'd2);
    send_item(MODE_WRITE, 6'd63);
    send_item(MODE_RELEASE, 6'd2);
    send_item(MODE_ALLOC, 6'd0);
    wait_idle();

    run_phase(7'd0, 7'd64, 260);
    run_phase(7'd1, 7'd64, 260);
    // upper policy bits ignored; hand left high by the last phase restarts at zero
    run_phase(7'd3, 7'd3, 120);
    run_phase(7'd0, 7'd5, 120);
    run_phase(7'd1, 7'd1, 60);
    run_phase(7'd0, 7'd0, 60);
    run_phase(7'd1, 7'd100, 160);
    run_phase(7'd1, 7'd17, 150);
    run_phase(7'd0, 7'd33, 160);

    while (sb.pending.size() != 0) begin
      sb.report($sformatf("frame %0d never reported", sb.pending[0].frame));
      void'(sb.pending.pop_front());
    end
    if (sb.errors == 0) begin
      $display("[page_frame_replacement] OK");
    end else begin
      $display("[page_frame_replacement] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_ram.sv
hw/rtl/page_frame_replacement.sv
tb/sv/tb_page_frame_replacement.sv
